// ===== hdl/crle_pkg.sv =====
// ----------------------------------------------------------------------------
// crle_pkg
// Shared types and constants for the CIGAR run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package crle_pkg;

    localparam int OUT_COUNT_BITS = 24;
    localparam int AMOUNT_BITS    = 24;
    localparam logic [7:0] GAP_CHAR = 8'h2D;    // '-'

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_FRAG   = 2'd1,
        KIND_COLUMN = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_M = 2'd0,
        OP_I = 2'd1,
        OP_D = 2'd2,
        OP_S = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_EXTEND = 2'd1,
        ACT_END    = 2'd2
    } t_action;

    // Classified command; amount is the run increment or, for start/end, the clip
    typedef struct packed {
        t_action                  action;
        t_op                      op;
        logic [AMOUNT_BITS-1:0]   amount;
    } t_cmd;

    typedef struct packed {
        logic                      final_op;
        t_op                       op_code;
        logic [OUT_COUNT_BITS-1:0] op_count;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/cigar_run_length_encoder.sv =====
// ----------------------------------------------------------------------------
// cigar_run_length_encoder
// Builds binary CIGAR operations (op, count) from a stream of alignment items.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per handshake; tuser is the item kind (read
//   start, fragment, alignment column, read end), tdata the other fields.
//   m_axis carries one CIGAR operation per handshake; tlast marks the last
//   operation of a read, raised only by a read-end item.
//   An item is taken every cycle while the command queue has room. The
//   front classifies it in the accept cycle; the back applies one command
//   per cycle to the open run. With nothing queued ahead, the first
//   operation of an item is registered in the command queue and then in
//   the result queue before it is valid on m_axis. An item yields at most
//   two operations; the back waits while the result queue has fewer than
//   two free slots.
//   When m_axis stalls the result queue fills, the back then stops, the
//   command queue fills and s_axis_tready drops; nothing is lost.
//   Reset (synchronous, active low) empties both queues, closes the open
//   run and clears the latched read length and strand.
//   COUNT_BITS sets the saturation point of counts; READ_LEN_BITS the
//   width to which read positions and lengths are reduced.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_run_length_encoder import crle_pkg::*; #(
    parameter int COUNT_BITS    = 24,
    parameter int READ_LEN_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // read_length[15:0], forward_strand[16], frag_is_simple[17],
    // frag_read_pos[33:18], frag_read_span[49:34], frag_ref_span[73:50],
    // ref_char[81:74], read_char[89:82], has_more_frags[90], zero[95:91]
    input  wire logic [95:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // op_code[1:0], op_count[25:2], zero[31:26]
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast    // final_op
);

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;
    localparam int CMD_LW    = $clog2(CMD_DEPTH+1);
    localparam int RES_LW    = $clog2(RES_DEPTH+1);
    localparam int CMD_W     = $bits(t_cmd);
    localparam int RES_W     = $bits(t_res);

    logic              cmd_push, cmd_valid, cmd_pop, cmd_full;
    t_cmd              cmd_in, cmd_out;
    logic [CMD_W-1:0]  cmd_q;
    logic [CMD_LW-1:0] cmd_level;

    logic              res_push0, res_push1, res_room;
    t_res              res0, res1, res_out;
    logic [RES_W-1:0]  res_q;
    logic [RES_LW-1:0] res_level;

    assign cmd_full = (cmd_level == CMD_LW'(CMD_DEPTH));
    assign res_room = (res_level <= RES_LW'(RES_DEPTH - 2));
    assign cmd_out  = t_cmd'(cmd_q);
    assign res_out  = t_res'(res_q);

    assign m_axis_tdata = {6'b0, res_out.op_count, res_out.op_code};
    assign m_axis_tlast = res_out.final_op;

    crle_front #(
        .READ_LEN_BITS(READ_LEN_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .i_kind     (s_axis_tuser),
        .o_push     (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    crle_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (cmd_push),
        .i_data0 (cmd_in),
        .i_push1 (1'b0),
        .i_data1 ({CMD_W{1'b0}}),
        .o_valid (cmd_valid),
        .o_data  (cmd_q),
        .i_pop   (cmd_pop),
        .o_level (cmd_level)
    );

    crle_back #(
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_room  (res_room),
        .o_push0     (res_push0),
        .o_res0      (res0),
        .o_push1     (res_push1),
        .o_res1      (res1)
    );

    crle_fifo #(
        .WIDTH(RES_W),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (res_push0),
        .i_data0 (res0),
        .i_push1 (res_push1),
        .i_data1 (res1),
        .o_valid (m_axis_tvalid),
        .o_data  (res_q),
        .i_pop   (m_axis_tready),
        .o_level (res_level)
    );

endmodule

`default_nettype wire

// ===== hdl/crle_fifo.sv =====
// ----------------------------------------------------------------------------
// crle_fifo
// Small synchronous FIFO, up to two items written and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push0,
    input  wire logic [WIDTH-1:0]           i_data0,
    input  wire logic                       i_push1,   // only together with i_push0
    input  wire logic [WIDTH-1:0]           i_data1,
    output logic                            o_valid,
    output logic [WIDTH-1:0]                o_data,
    input  wire logic                       i_pop,
    output logic [$clog2(DEPTH+1)-1:0]      o_level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [LW-1:0]    r_level,  n_level;
    logic             pop;
    logic [PW-1:0]    wr_ptr1;

    assign pop     = i_pop && (r_level != '0);
    assign wr_ptr1 = r_wr_ptr + PW'(1);
    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push0) + PW'(i_push1);
        n_rd_ptr = r_rd_ptr + PW'(pop);
        n_level  = r_level + LW'(i_push0) + LW'(i_push1) - LW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/crle_front.sv =====
// ----------------------------------------------------------------------------
// crle_front
// Accepts input items, latches read length and strand, works out clip
// lengths and classifies each item into a run command.
// ----------------------------------------------------------------------------
`default_nettype none

module crle_front import crle_pkg::*; #(
    parameter int READ_LEN_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [95:0] i_data,
    input  wire logic [1:0]  i_kind,
    output logic             o_push,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_full
);

    localparam logic [15:0] RL_MASK = (READ_LEN_BITS >= 16) ? 16'hFFFF :
                                      16'((32'd1 << READ_LEN_BITS) - 32'd1);

    logic [15:0] r_read_len, n_read_len;
    logic        r_forward,  n_forward;

    logic        accept;
    logic [15:0] rlen, pos, span;
    logic        fwd, simple, more;
    logic [23:0] gspan;
    logic [7:0]  ref_char, read_char;
    logic [15:0] clip_start, clip_end;
    logic        has_cmd;

    function automatic logic [15:0] tail_clip(input logic [15:0] rl,
                                              input logic [15:0] p,
                                              input logic [15:0] s);
        logic [16:0] used;
        used = {1'b0, p} + {1'b0, s};
        if ({1'b0, rl} > used) begin
            return 16'({1'b0, rl} - used);
        end
        return '0;
    endfunction

    assign rlen      = i_data[15:0] & RL_MASK;
    assign fwd       = i_data[16];
    assign simple    = i_data[17];
    assign pos       = i_data[33:18] & RL_MASK;
    assign span      = i_data[49:34] & RL_MASK;
    assign gspan     = i_data[73:50];
    assign ref_char  = i_data[81:74];
    assign read_char = i_data[89:82];
    assign more      = i_data[90];

    assign o_ready = !i_cmd_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && has_cmd;

    // Leading clip uses the strand of this item, trailing clip the latched one
    assign clip_start = simple ? 16'd0 : (fwd ? pos : tail_clip(rlen, pos, span));
    assign clip_end   = (!more || simple) ? 16'd0 :
                        (r_forward ? tail_clip(r_read_len, pos, span) : pos);

    always_comb begin
        has_cmd      = 1'b1;
        o_cmd.action = ACT_EXTEND;
        o_cmd.op     = OP_M;
        o_cmd.amount = '0;
        n_read_len   = r_read_len;
        n_forward    = r_forward;
        unique case (t_kind'(i_kind))
            KIND_START: begin
                o_cmd.action = ACT_START;
                o_cmd.op     = OP_S;
                o_cmd.amount = AMOUNT_BITS'(clip_start);
                if (accept) begin
                    n_read_len = rlen;
                    n_forward  = fwd;
                end
            end
            KIND_FRAG: begin
                priority if (simple) begin
                    o_cmd.amount = AMOUNT_BITS'(span);
                end else if (span != '0) begin
                    o_cmd.op     = OP_I;
                    o_cmd.amount = AMOUNT_BITS'(span);
                end else if (gspan != '0) begin
                    o_cmd.op     = OP_D;
                    o_cmd.amount = gspan;
                end else begin
                    has_cmd = 1'b0;
                end
            end
            KIND_COLUMN: begin
                o_cmd.amount = AMOUNT_BITS'(1);
                priority if (read_char == GAP_CHAR) begin
                    o_cmd.op = OP_D;
                end else if (ref_char == GAP_CHAR) begin
                    o_cmd.op = OP_I;
                end else begin
                    o_cmd.op = OP_M;
                end
            end
            KIND_END: begin
                o_cmd.action = ACT_END;
                o_cmd.op     = OP_S;
                o_cmd.amount = AMOUNT_BITS'(clip_end);
            end
            default: begin
                has_cmd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_len <= '0;
            r_forward  <= 1'b0;
        end else begin
            r_read_len <= n_read_len;
            r_forward  <= n_forward;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/crle_back.sv =====
// ----------------------------------------------------------------------------
// crle_back
// Holds the open run, applies one command per cycle while the result queue
// has two free slots, and writes up to two CIGAR operations into it.
// ----------------------------------------------------------------------------
`default_nettype none

module crle_back import crle_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_res_room,     // at least two free result slots
    output logic      o_push0,
    output t_res      o_res0,
    output logic      o_push1,
    output t_res      o_res1
);

    localparam int SW = ((COUNT_BITS > AMOUNT_BITS) ? COUNT_BITS : AMOUNT_BITS) + 1;
    localparam logic [SW-1:0] CNT_MAX = SW'((64'd1 << COUNT_BITS) - 64'd1);

    t_op                   r_run_op,    n_run_op;
    logic                  r_run_valid, n_run_valid;
    logic [COUNT_BITS-1:0] r_run_count, n_run_count;

    logic                  change, flush_run, has_clip;
    logic [COUNT_BITS-1:0] base;
    logic [SW-1:0]         sum;
    t_res                  run_res, clip_res;

    function automatic logic [COUNT_BITS-1:0] sat_cb(input logic [SW-1:0] v);
        if (v > CNT_MAX) begin
            return '1;
        end
        return v[COUNT_BITS-1:0];
    endfunction

    function automatic logic [OUT_COUNT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] c);
        logic [SW-1:0] ext;
        ext = SW'(c);
        return ext[OUT_COUNT_BITS-1:0];
    endfunction

    assign o_cmd_pop = i_cmd_valid && i_res_room;
    assign change    = !r_run_valid || (r_run_op != i_cmd.op);
    assign base      = change ? '0 : r_run_count;
    assign sum       = SW'(base) + SW'(i_cmd.amount);
    assign flush_run = (r_run_count != '0);
    assign has_clip  = (i_cmd.amount != '0);

    always_comb begin
        run_res.final_op  = 1'b0;
        run_res.op_code   = r_run_op;
        run_res.op_count  = to_out(r_run_count);
        clip_res.final_op = 1'b0;
        clip_res.op_code  = OP_S;
        clip_res.op_count = to_out(sat_cb(SW'(i_cmd.amount)));

        n_run_op    = r_run_op;
        n_run_valid = r_run_valid;
        n_run_count = r_run_count;
        o_push0     = 1'b0;
        o_push1     = 1'b0;
        o_res0      = clip_res;
        o_res1      = clip_res;

        if (o_cmd_pop) begin
            unique case (i_cmd.action)
                ACT_START: begin
                    n_run_valid = 1'b0;
                    n_run_op    = OP_M;
                    n_run_count = '0;
                    o_push0     = has_clip;
                end
                ACT_EXTEND: begin
                    o_push0     = change && flush_run;
                    o_res0      = run_res;
                    n_run_op    = i_cmd.op;
                    n_run_valid = 1'b1;
                    n_run_count = sat_cb(sum);
                end
                ACT_END: begin
                    n_run_valid = 1'b0;
                    n_run_op    = OP_M;
                    n_run_count = '0;
                    o_res1.final_op = 1'b1;
                    if (flush_run) begin
                        o_push0          = 1'b1;
                        o_res0           = run_res;
                        o_res0.final_op  = !has_clip;
                        o_push1          = has_clip;
                    end else begin
                        o_push0         = has_clip;
                        o_res0.final_op = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_op <= n_run_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_run_count <= '0;
        end else begin
            r_run_valid <= n_run_valid;
            r_run_count <= n_run_count;
        end
    end

endmodule

`default_nettype wire
